/* design/mdc_pkg.sv */
// Shared types, codes and default sizes of the MESI direct-mapped cache.
`default_nettype none

package mdc_pkg;

    localparam int NUM_SETS_DEF     = 64;
    localparam int WORDS_DEF        = 8;
    localparam int ADDRESS_BITS_DEF = 21;
    localparam int DATA_BITS_DEF    = 32;

    localparam int OP_W   = 3;
    localparam int KIND_W = 3;

    localparam logic BUS_RD  = 1'b0;
    localparam logic BUS_RDX = 1'b1;

    typedef enum logic [1:0] {
        MESI_I = 2'd0,
        MESI_S = 2'd1,
        MESI_E = 2'd2,
        MESI_M = 2'd3
    } t_mesi;

    typedef enum logic [2:0] {
        OP_READ      = 3'd0,
        OP_WRITE     = 3'd1,
        OP_SNOOP_RD  = 3'd2,
        OP_SNOOP_RDX = 3'd3,
        OP_FILL      = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        KIND_DONE  = 3'd0,
        KIND_WAIT  = 3'd1,
        KIND_REQ   = 3'd2,
        KIND_WB    = 3'd3,
        KIND_SNOOP = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        SNOOP_NONE   = 2'd0,
        SNOOP_SHARED = 2'd1,
        SNOOP_FLUSH  = 2'd2
    } t_snoop;

    typedef enum logic [2:0] {
        FSM_CLEAR  = 3'd0,
        FSM_IDLE   = 3'd1,
        FSM_LOOK   = 3'd2,
        FSM_WB_RD  = 3'd3,
        FSM_WB_OUT = 3'd4
    } t_fsm;

endpackage

`default_nettype wire

/* design/mdc_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module mdc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/mesi_direct_mapped_cache.sv */
// Top level: MESI direct-mapped write-back cache controller over tag and data RAMs.
// A hit, wait answer, request or clean snoop reads the RAMs, then is decided in the LOOK state.
// A Modified victim or flushed line first adds a write-back of all WORDS_PER_BLOCK words:
// after the decision, each block word is read from the data RAM (WB_RD), then emitted (WB_OUT).
// Throughput: one word at a time; a fill word is taken while idle and yields no result.
// Reset: a clearing pass writes every tag RAM entry to Invalid, during which no word
// is accepted; the data RAM is left undefined.
`default_nettype none

module mesi_direct_mapped_cache #(
    parameter int NUM_SETS        = mdc_pkg::NUM_SETS_DEF,
    parameter int WORDS_PER_BLOCK = mdc_pkg::WORDS_DEF,
    parameter int ADDRESS_BITS    = mdc_pkg::ADDRESS_BITS_DEF,
    parameter int DATA_BITS       = mdc_pkg::DATA_BITS_DEF,
    localparam int OB    = $clog2(WORDS_PER_BLOCK),
    localparam int SB    = $clog2(NUM_SETS),
    localparam int TB    = ADDRESS_BITS - OB - SB,
    localparam int IN_W  = ((ADDRESS_BITS + DATA_BITS + 1 + 7) / 8) * 8,
    localparam int OUT_W = ((ADDRESS_BITS + DATA_BITS + 4 + 7) / 8) * 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_tvalid,
    output logic                           o_s_tready,
    // address, store_data, shared_line
    input  wire logic [IN_W-1:0]           i_s_tdata,
    // operation
    input  wire logic [mdc_pkg::OP_W-1:0]  i_s_tuser,
    output logic                           o_m_tvalid,
    input  wire logic                      i_m_tready,
    // hit, result_address, result_data, bus_command, snoop_status
    output logic [OUT_W-1:0]               o_m_tdata,
    // kind
    output logic [mdc_pkg::KIND_W-1:0]     o_m_tuser,
    output logic                           o_m_tlast
);

    localparam int TW = TB + 2;

    // input decode
    logic [ADDRESS_BITS-1:0] w_in_addr;
    logic [DATA_BITS-1:0]    w_in_wdata;
    logic                    w_in_shared;
    logic [OB-1:0]           w_in_off;
    logic [SB-1:0]           w_in_set;
    logic [TB-1:0]           w_in_tag;
    logic                    w_in_acc;
    logic                    w_in_core_snoop;

    assign w_in_addr   = i_s_tdata[ADDRESS_BITS-1:0];
    assign w_in_wdata  = i_s_tdata[ADDRESS_BITS +: DATA_BITS];
    assign w_in_shared = i_s_tdata[ADDRESS_BITS + DATA_BITS];
    assign w_in_off    = w_in_addr[OB-1:0];
    assign w_in_set    = w_in_addr[OB +: SB];
    assign w_in_tag    = w_in_addr[ADDRESS_BITS-1 -: TB];

    // registers
    mdc_pkg::t_fsm           r_fsm, n_fsm;
    logic [mdc_pkg::OP_W-1:0] r_op;
    logic [ADDRESS_BITS-1:0] r_addr;
    logic [DATA_BITS-1:0]    r_wdata;
    logic                    r_wb_done;
    logic [OB-1:0]           r_cnt;
    logic [SB-1:0]           r_clr;
    logic                    r_waiting, n_waiting;
    logic                    r_fin, n_fin;
    logic                    r_pend, n_pend;

    logic                    r_o_valid;
    mdc_pkg::t_kind          r_o_kind;
    logic                    r_o_hit;
    logic [ADDRESS_BITS-1:0] r_o_addr;
    logic [DATA_BITS-1:0]    r_o_data;
    logic                    r_o_cmd;
    mdc_pkg::t_snoop         r_o_stat;
    logic                    r_o_last;

    logic [OB-1:0] w_off;
    logic [SB-1:0] w_set;
    logic [TB-1:0] w_tag;
    logic          w_wr;

    assign w_off = r_addr[OB-1:0];
    assign w_set = r_addr[OB +: SB];
    assign w_tag = r_addr[ADDRESS_BITS-1 -: TB];
    assign w_wr  = (r_op == mdc_pkg::OP_WRITE);

    // RAM ports
    logic             w_twe;
    logic [SB-1:0]    w_twaddr;
    logic [TW-1:0]    w_twdata;
    logic [SB-1:0]    w_traddr;
    logic [TW-1:0]    w_trdata;
    logic             w_dwe;
    logic [OB+SB-1:0] w_dwaddr;
    logic [DATA_BITS-1:0] w_dwdata;
    logic [OB+SB-1:0] w_draddr;
    logic [DATA_BITS-1:0] w_drdata;

    mdc_ram #(.WIDTH(TW), .DEPTH(NUM_SETS)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_twe),
        .i_waddr (w_twaddr),
        .i_wdata (w_twdata),
        .i_raddr (w_traddr),
        .o_rdata (w_trdata)
    );

    mdc_ram #(.WIDTH(DATA_BITS), .DEPTH(NUM_SETS * WORDS_PER_BLOCK)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_dwe),
        .i_waddr (w_dwaddr),
        .i_wdata (w_dwdata),
        .i_raddr (w_draddr),
        .o_rdata (w_drdata)
    );

    logic [TB-1:0]   w_line_tag;
    mdc_pkg::t_mesi  w_line_st;
    logic            w_held;
    logic            w_out_free;

    assign w_line_tag = w_trdata[TW-1:2];
    assign w_line_st  = mdc_pkg::t_mesi'(w_trdata[1:0]);
    assign w_held     = (w_line_st != mdc_pkg::MESI_I) && (w_line_tag == w_tag);
    assign w_out_free = !r_o_valid || i_m_tready;

    assign o_s_tready      = (r_fsm == mdc_pkg::FSM_IDLE);
    assign w_in_acc        = i_s_tvalid && o_s_tready;
    assign w_in_core_snoop = (i_s_tuser == mdc_pkg::OP_READ) ||
                             (i_s_tuser == mdc_pkg::OP_WRITE) ||
                             (i_s_tuser == mdc_pkg::OP_SNOOP_RD) ||
                             (i_s_tuser == mdc_pkg::OP_SNOOP_RDX);

    always_comb begin
        w_traddr = w_set;
        w_draddr = {w_set, w_off};
        unique case (r_fsm)
            mdc_pkg::FSM_IDLE: begin
                w_traddr = w_in_set;
                w_draddr = {w_in_set, w_in_off};
            end
            mdc_pkg::FSM_WB_RD, mdc_pkg::FSM_WB_OUT: begin
                w_draddr = {w_set, r_cnt};
            end
            default: begin
            end
        endcase
    end

    // result and write-back decisions
    logic                    w_emit;
    logic                    w_need_wb;
    mdc_pkg::t_kind          e_kind;
    logic                    e_hit;
    logic [ADDRESS_BITS-1:0] e_addr;
    logic [DATA_BITS-1:0]    e_data;
    logic                    e_cmd;
    mdc_pkg::t_snoop         e_stat;
    logic                    e_last;

    always_comb begin
        w_emit    = 1'b0;
        w_need_wb = 1'b0;
        e_kind    = mdc_pkg::KIND_DONE;
        e_hit     = 1'b0;
        e_addr    = r_addr;
        e_data    = '0;
        e_cmd     = mdc_pkg::BUS_RD;
        e_stat    = mdc_pkg::SNOOP_NONE;
        e_last    = 1'b1;
        w_twe     = 1'b0;
        w_twaddr  = w_set;
        w_twdata  = {w_line_tag, mdc_pkg::MESI_M};
        w_dwe     = 1'b0;
        w_dwaddr  = {w_set, w_off};
        w_dwdata  = r_wdata;
        n_waiting = r_waiting;
        n_fin     = r_fin;
        n_pend    = r_pend;
        unique case (r_fsm)
            mdc_pkg::FSM_CLEAR: begin
                w_twe    = 1'b1;
                w_twaddr = r_clr;
                w_twdata = {{TB{1'b0}}, mdc_pkg::MESI_I};
            end
            mdc_pkg::FSM_IDLE: begin
                if (w_in_acc && i_s_tuser == mdc_pkg::OP_FILL && r_waiting && !r_fin) begin
                    w_dwe    = 1'b1;
                    w_dwaddr = {w_in_set, w_in_off};
                    w_dwdata = w_in_wdata;
                    if (w_in_off == OB'(WORDS_PER_BLOCK - 1)) begin
                        w_twe    = 1'b1;
                        w_twaddr = w_in_set;
                        if (r_pend) begin
                            w_twdata = {w_in_tag, mdc_pkg::MESI_M};
                        end else if (w_in_shared) begin
                            w_twdata = {w_in_tag, mdc_pkg::MESI_S};
                        end else begin
                            w_twdata = {w_in_tag, mdc_pkg::MESI_E};
                        end
                        n_fin = 1'b1;
                    end
                end
            end
            mdc_pkg::FSM_LOOK: begin
                if (r_op == mdc_pkg::OP_READ || r_op == mdc_pkg::OP_WRITE) begin
                    priority if (r_waiting && !r_fin) begin
                        e_kind = mdc_pkg::KIND_WAIT;
                        w_emit = w_out_free;
                    end else if (r_waiting ||
                                 (w_held && !(w_wr && w_line_st == mdc_pkg::MESI_S))) begin
                        e_kind = mdc_pkg::KIND_DONE;
                        e_hit  = !r_waiting;
                        e_data = w_wr ? '0 : w_drdata;
                        w_emit = w_out_free;
                        if (w_out_free) begin
                            n_waiting = 1'b0;
                            n_fin     = 1'b0;
                            w_dwe     = w_wr;
                            w_twe     = w_wr;
                        end
                    end else if (w_line_st == mdc_pkg::MESI_M && !r_wb_done) begin
                        w_need_wb = 1'b1;
                    end else begin
                        e_kind = mdc_pkg::KIND_REQ;
                        e_cmd  = w_wr ? mdc_pkg::BUS_RDX : mdc_pkg::BUS_RD;
                        w_emit = w_out_free;
                        if (w_out_free) begin
                            n_waiting = 1'b1;
                            n_fin     = 1'b0;
                            n_pend    = w_wr;
                        end
                    end
                end else begin
                    if (w_held && w_line_st == mdc_pkg::MESI_M && !r_wb_done) begin
                        w_need_wb = 1'b1;
                    end else begin
                        e_kind = mdc_pkg::KIND_SNOOP;
                        if (!w_held) begin
                            e_stat = mdc_pkg::SNOOP_NONE;
                        end else if (w_line_st == mdc_pkg::MESI_M) begin
                            e_stat = mdc_pkg::SNOOP_FLUSH;
                        end else begin
                            e_stat = mdc_pkg::SNOOP_SHARED;
                        end
                        w_emit = w_out_free;
                        w_twe  = w_out_free && w_held;
                        if (r_op == mdc_pkg::OP_SNOOP_RD) begin
                            w_twdata = {w_line_tag, mdc_pkg::MESI_S};
                        end else begin
                            w_twdata = {w_line_tag, mdc_pkg::MESI_I};
                        end
                    end
                end
            end
            mdc_pkg::FSM_WB_OUT: begin
                e_kind = mdc_pkg::KIND_WB;
                e_addr = {w_line_tag, w_set, r_cnt};
                e_data = w_drdata;
                e_last = 1'b0;
                w_emit = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            mdc_pkg::FSM_CLEAR: begin
                if (r_clr == SB'(NUM_SETS - 1)) begin
                    n_fsm = mdc_pkg::FSM_IDLE;
                end
            end
            mdc_pkg::FSM_IDLE: begin
                if (w_in_acc && w_in_core_snoop) begin
                    n_fsm = mdc_pkg::FSM_LOOK;
                end
            end
            mdc_pkg::FSM_LOOK: begin
                if (w_need_wb) begin
                    n_fsm = mdc_pkg::FSM_WB_RD;
                end else if (w_emit) begin
                    n_fsm = mdc_pkg::FSM_IDLE;
                end
            end
            mdc_pkg::FSM_WB_RD: begin
                n_fsm = mdc_pkg::FSM_WB_OUT;
            end
            mdc_pkg::FSM_WB_OUT: begin
                if (w_emit) begin
                    if (r_cnt == OB'(WORDS_PER_BLOCK - 1)) begin
                        n_fsm = mdc_pkg::FSM_LOOK;
                    end else begin
                        n_fsm = mdc_pkg::FSM_WB_RD;
                    end
                end
            end
            default: begin
                n_fsm = mdc_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm     <= mdc_pkg::FSM_CLEAR;
            r_clr     <= '0;
            r_cnt     <= '0;
            r_wb_done <= 1'b0;
            r_waiting <= 1'b0;
            r_fin     <= 1'b0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_fsm     <= n_fsm;
            r_waiting <= n_waiting;
            r_fin     <= n_fin;
            r_pend    <= n_pend;
            if (r_fsm == mdc_pkg::FSM_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_in_acc) begin
                r_wb_done <= 1'b0;
            end
            if (w_need_wb) begin
                r_cnt <= '0;
            end else if (r_fsm == mdc_pkg::FSM_WB_OUT && w_emit) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == OB'(WORDS_PER_BLOCK - 1)) begin
                    r_wb_done <= 1'b1;
                end
            end
            if (w_emit) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op    <= i_s_tuser;
            r_addr  <= w_in_addr;
            r_wdata <= w_in_wdata;
        end
        if (w_emit) begin
            r_o_kind <= e_kind;
            r_o_hit  <= e_hit;
            r_o_addr <= e_addr;
            r_o_data <= e_data;
            r_o_cmd  <= e_cmd;
            r_o_stat <= e_stat;
            r_o_last <= e_last;
        end
    end

    always_comb begin
        o_m_tdata                                    = '0;
        o_m_tdata[0]                                 = r_o_hit;
        o_m_tdata[1 +: ADDRESS_BITS]                 = r_o_addr;
        o_m_tdata[1 + ADDRESS_BITS +: DATA_BITS]     = r_o_data;
        o_m_tdata[1 + ADDRESS_BITS + DATA_BITS]      = r_o_cmd;
        o_m_tdata[2 + ADDRESS_BITS + DATA_BITS +: 2] = r_o_stat;
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tuser  = r_o_kind;
    assign o_m_tlast  = r_o_last;

`ifndef SYNTH
    a_wb_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == mdc_pkg::KIND_WB) |-> !o_m_tlast)
        else $error("writeback word marked last");

    a_req_sets_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == mdc_pkg::FSM_LOOK && w_emit && e_kind == mdc_pkg::KIND_REQ) |=> r_waiting)
        else $error("bus request did not start a fill wait");

    a_fin_needs_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> r_waiting)
        else $error("fill finished without a pending miss");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == mdc_pkg::FSM_CLEAR) |-> (!o_s_tready && !w_emit))
        else $error("activity during tag clearing pass");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_mesi_direct_mapped_cache.sv */
// Self-checking testbench of the MESI direct-mapped cache: directed table, then random traffic.
module tb_mesi_direct_mapped_cache;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W         = 56;
    localparam int OUT_W        = 64;
    localparam int RANDOM_ITEMS = 240;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 48;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    localparam logic [2:0] OP_CODE_RSVD = 3'd5;
    localparam logic [2:0] OP_CODE_MAX  = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [20:0] addr;
        logic [31:0] data;
        logic        shared;
    } t_cache_item;

    typedef struct packed {
        mdc_pkg::t_kind  kind;
        logic            hit;
        logic [20:0]     addr;
        logic [31:0]     data;
        logic            cmd;
        mdc_pkg::t_snoop status;
        logic            last;
    } t_resp;

    typedef struct packed {
        t_cache_item item;
        logic        typed;
        logic        has_resp;
        t_resp       resp;
    } t_stim_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_tvalid;
    logic             o_s_tready;
    logic [IN_W-1:0]  i_s_tdata;   // address, store_data, shared_line
    logic [mdc_pkg::OP_W-1:0]   i_s_tuser;   // operation
    logic             o_m_tvalid;
    logic             i_m_tready;
    logic [OUT_W-1:0] o_m_tdata;   // hit, result_address, result_data, bus_command, snoop_status
    logic [mdc_pkg::KIND_W-1:0] o_m_tuser;   // kind
    logic             o_m_tlast;

    mesi_direct_mapped_cache i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    logic [11:0]    tag_mem [64];
    mdc_pkg::t_mesi line_mem [64];
    logic [31:0]    data_mem [512];
    bit             word_written [512];
    bit             fill_wait;
    bit             fill_done;
    bit             fill_excl;
    logic [17:0]    fill_block;
    logic [2:0]     fill_next;

    t_resp       step_words [$];
    t_resp       responses_due [$];
    t_stim_row   directed [$];

    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_ask;
    int hold_left;
    int mismatches;
    int words_checked;
    int items_sent;
    int wb_words;
    int flushes;
    int cycle_count;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_mesi_direct_mapped_cache failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_ask) begin
            hold_ask = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on %s at word %0d: expected %h, got %h",
                         name, words_checked, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_resp want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (responses_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: kind %0d address %h data %h",
                             o_m_tuser, o_m_tdata[21:1], o_m_tdata[53:22]);
            end else begin
                want = responses_due.pop_front();
                check_field("kind", 32'(want.kind), 32'(o_m_tuser));
                check_field("hit", 32'(want.hit), 32'(o_m_tdata[0]));
                check_field("result_address", 32'(want.addr), 32'(o_m_tdata[21:1]));
                check_field("result_data", want.data, o_m_tdata[53:22]);
                check_field("bus_command", 32'(want.cmd), 32'(o_m_tdata[54]));
                check_field("snoop_status", 32'(want.status), 32'(o_m_tdata[56:55]));
                check_field("last", 32'(want.last), 32'(o_m_tlast));
            end
            words_checked++;
        end
    end

    function automatic t_resp resp_of(input mdc_pkg::t_kind k, input logic h,
                                      input logic [20:0] a, input logic [31:0] d,
                                      input logic c, input mdc_pkg::t_snoop s,
                                      input logic l);
        t_resp r;
        r.kind   = k;
        r.hit    = h;
        r.addr   = a;
        r.data   = d;
        r.cmd    = c;
        r.status = s;
        r.last   = l;
        return r;
    endfunction

    function automatic t_cache_item item_of(input logic [2:0] op, input logic [20:0] a,
                                            input logic [31:0] d, input logic sh);
        t_cache_item it;
        it.op     = op;
        it.addr   = a;
        it.data   = d;
        it.shared = sh;
        return it;
    endfunction

    function automatic bit block_written(input logic [5:0] idx);
        for (int w = 0; w < 8; w++)
            if (!word_written[{idx, 3'(w)}])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void flush_line(input logic [5:0] idx);
        for (int w = 0; w < 8; w++)
            step_words.push_back(resp_of(mdc_pkg::KIND_WB, 1'b0, {tag_mem[idx], idx, 3'(w)},
                                         data_mem[{idx, 3'(w)}], mdc_pkg::BUS_RD,
                                         mdc_pkg::SNOOP_NONE, 1'b0));
    endfunction

    function automatic void reset_cache_state();
        for (int s = 0; s < 64; s++) begin
            tag_mem[s]  = '0;
            line_mem[s] = mdc_pkg::MESI_I;
        end
        for (int w = 0; w < 512; w++) begin
            data_mem[w]     = '0;
            word_written[w] = 1'b0;
        end
        fill_wait  = 1'b0;
        fill_done  = 1'b0;
        fill_excl  = 1'b0;
        fill_block = '0;
        fill_next  = '0;
    endfunction

    function automatic void predict_mesi_step(input t_cache_item it, input bit record,
                                              output bit effect);
        logic [2:0]      offs;
        logic [5:0]      idx;
        logic [11:0]     tag;
        logic [8:0]      di;
        bit              held;
        bit              wr;
        mdc_pkg::t_snoop st;
        t_resp           r;
        offs = it.addr[2:0];
        idx  = it.addr[8:3];
        tag  = it.addr[20:9];
        di   = {idx, offs};
        held = line_mem[idx] != mdc_pkg::MESI_I && tag_mem[idx] == tag;
        wr   = it.op == mdc_pkg::OP_WRITE;
        effect = 1'b1;
        step_words.delete();
        case (it.op)
            mdc_pkg::OP_READ, mdc_pkg::OP_WRITE: begin
                if (fill_wait && !fill_done) begin
                    step_words.push_back(resp_of(mdc_pkg::KIND_WAIT, 1'b0, it.addr, '0,
                                                 mdc_pkg::BUS_RD, mdc_pkg::SNOOP_NONE, 1'b0));
                end else if (fill_wait) begin
                    fill_wait = 1'b0;
                    fill_done = 1'b0;
                    if (wr) begin
                        data_mem[di]     = it.data;
                        word_written[di] = 1'b1;
                        line_mem[idx]    = mdc_pkg::MESI_M;
                    end
                    step_words.push_back(resp_of(mdc_pkg::KIND_DONE, 1'b0, it.addr,
                                                 wr ? '0 : data_mem[di], mdc_pkg::BUS_RD,
                                                 mdc_pkg::SNOOP_NONE, 1'b0));
                end else if (held && !(wr && line_mem[idx] == mdc_pkg::MESI_S)) begin
                    if (wr) begin
                        data_mem[di]     = it.data;
                        word_written[di] = 1'b1;
                        line_mem[idx]    = mdc_pkg::MESI_M;
                    end
                    step_words.push_back(resp_of(mdc_pkg::KIND_DONE, 1'b1, it.addr,
                                                 wr ? '0 : data_mem[di], mdc_pkg::BUS_RD,
                                                 mdc_pkg::SNOOP_NONE, 1'b0));
                end else begin
                    if (line_mem[idx] == mdc_pkg::MESI_M)
                        flush_line(idx);
                    step_words.push_back(resp_of(mdc_pkg::KIND_REQ, 1'b0, it.addr, '0,
                                                 wr ? mdc_pkg::BUS_RDX : mdc_pkg::BUS_RD,
                                                 mdc_pkg::SNOOP_NONE, 1'b0));
                    fill_wait  = 1'b1;
                    fill_done  = 1'b0;
                    fill_excl  = wr;
                    fill_block = it.addr[20:3];
                    fill_next  = '0;
                end
            end
            mdc_pkg::OP_SNOOP_RD, mdc_pkg::OP_SNOOP_RDX: begin
                st = mdc_pkg::SNOOP_NONE;
                if (held) begin
                    st = mdc_pkg::SNOOP_SHARED;
                    if (line_mem[idx] == mdc_pkg::MESI_M) begin
                        flush_line(idx);
                        st = mdc_pkg::SNOOP_FLUSH;
                    end
                    line_mem[idx] = (it.op == mdc_pkg::OP_SNOOP_RD) ? mdc_pkg::MESI_S
                                                                    : mdc_pkg::MESI_I;
                end
                step_words.push_back(resp_of(mdc_pkg::KIND_SNOOP, 1'b0, it.addr, '0,
                                             mdc_pkg::BUS_RD, st, 1'b0));
            end
            mdc_pkg::OP_FILL: begin
                if (fill_wait && !fill_done) begin
                    data_mem[di]     = it.data;
                    word_written[di] = 1'b1;
                    if (it.addr[20:3] == fill_block)
                        fill_next = offs + 3'd1;
                    if (offs == 3'd7) begin
                        tag_mem[idx] = tag;
                        if (fill_excl)
                            line_mem[idx] = mdc_pkg::MESI_M;
                        else
                            line_mem[idx] = it.shared ? mdc_pkg::MESI_S : mdc_pkg::MESI_E;
                        fill_done = 1'b1;
                    end
                end else begin
                    effect = 1'b0;
                end
            end
            default: effect = 1'b0;
        endcase
        if (step_words.size() > 0)
            step_words[step_words.size() - 1].last = 1'b1;
        if (record) begin
            foreach (step_words[i]) begin
                r = step_words[i];
                if (r.kind == mdc_pkg::KIND_WB)
                    wb_words++;
                if (r.kind == mdc_pkg::KIND_SNOOP && r.status == mdc_pkg::SNOOP_FLUSH)
                    flushes++;
                responses_due.push_back(r);
            end
        end
    endfunction

    function automatic bit touches_unwritten(input t_cache_item it);
        logic [5:0] idx;
        logic [8:0] di;
        bit         held;
        bit         wr;
        idx  = it.addr[8:3];
        di   = it.addr[8:0];
        held = line_mem[idx] != mdc_pkg::MESI_I && tag_mem[idx] == it.addr[20:9];
        wr   = it.op == mdc_pkg::OP_WRITE;
        if (it.op == mdc_pkg::OP_READ || it.op == mdc_pkg::OP_WRITE) begin
            if (fill_wait)
                return fill_done && !wr && !word_written[di];
            if (held && !(wr && line_mem[idx] == mdc_pkg::MESI_S))
                return !wr && !word_written[di];
            return line_mem[idx] == mdc_pkg::MESI_M && !block_written(idx);
        end
        if (it.op == mdc_pkg::OP_SNOOP_RD || it.op == mdc_pkg::OP_SNOOP_RDX)
            return held && line_mem[idx] == mdc_pkg::MESI_M && !block_written(idx);
        return 1'b0;
    endfunction

    function automatic logic [20:0] pick_address();
        logic [11:0] tag;
        logic [5:0]  idx;
        int          r;
        r = $urandom_range(99);
        if (r < 10)
            return 21'($urandom);
        if (r < 45)
            return {fill_block, 3'($urandom_range(7))};
        case ($urandom_range(3))
            0:       tag = 12'h000;
            1:       tag = 12'hFFF;
            2:       tag = 12'h555;
            default: tag = 12'hAAA;
        endcase
        case ($urandom_range(3))
            0:       idx = 6'h00;
            1:       idx = 6'h3F;
            2:       idx = 6'h15;
            default: idx = 6'h2A;
        endcase
        return {tag, idx, 3'($urandom_range(7))};
    endfunction

    function automatic t_cache_item next_item();
        t_cache_item it;
        int          r;
        it.data   = $urandom;
        it.shared = 1'($urandom_range(1));
        it.addr   = pick_address();
        r = $urandom_range(99);
        if (fill_wait && !fill_done) begin
            if (r < 78) begin
                it.op   = mdc_pkg::OP_FILL;
                it.addr = {fill_block, fill_next};
            end else if (r < 86) begin
                it.op = $urandom_range(1) ? mdc_pkg::OP_WRITE : mdc_pkg::OP_READ;
            end else if (r < 94) begin
                it.op = $urandom_range(1) ? mdc_pkg::OP_SNOOP_RDX : mdc_pkg::OP_SNOOP_RD;
            end else if (r < 97) begin
                it.op = mdc_pkg::OP_FILL;
            end else begin
                it.op   = mdc_pkg::OP_FILL;
                it.addr = {fill_block, 3'd7};
            end
        end else begin
            if (r < 62)
                it.op = $urandom_range(1) ? mdc_pkg::OP_WRITE : mdc_pkg::OP_READ;
            else if (r < 88)
                it.op = $urandom_range(1) ? mdc_pkg::OP_SNOOP_RDX : mdc_pkg::OP_SNOOP_RD;
            else if (r < 94)
                it.op = mdc_pkg::OP_FILL;
            else
                it.op = 3'($urandom_range(OP_CODE_RSVD, OP_CODE_MAX));
        end
        return it;
    endfunction

    function automatic void add_row(input t_cache_item it, input bit typed, input bit has_resp,
                                    input t_resp r);
        t_stim_row row;
        row.item     = it;
        row.typed    = typed;
        row.has_resp = has_resp;
        row.resp     = r;
        directed.push_back(row);
    endfunction

    function automatic void build_directed();
        logic [31:0] pat [8];
        pat = '{32'h80000000, 32'h7FFFFFFF, 32'h00000000, 32'hFFFFFFFF,
                32'h55555555, 32'hAAAAAAAA, 32'h00000001, 32'hFFFFFFFE};
        add_row(item_of(mdc_pkg::OP_SNOOP_RD, 21'h000000, 32'h0, 1'b0), 1'b1, 1'b1,
                resp_of(mdc_pkg::KIND_SNOOP, 1'b0, 21'h000000, '0, mdc_pkg::BUS_RD,
                        mdc_pkg::SNOOP_NONE, 1'b1));
        add_row(item_of(mdc_pkg::OP_SNOOP_RDX, 21'h1FFFFF, 32'hFFFFFFFF, 1'b1), 1'b1, 1'b1,
                resp_of(mdc_pkg::KIND_SNOOP, 1'b0, 21'h1FFFFF, '0, mdc_pkg::BUS_RD,
                        mdc_pkg::SNOOP_NONE, 1'b1));
        add_row(item_of(OP_CODE_MAX, 21'h1FFFFF, 32'hFFFFFFFF, 1'b1), 1'b1, 1'b0, '0);
        add_row(item_of(mdc_pkg::OP_FILL, 21'h000007, 32'h12345678, 1'b0), 1'b1, 1'b0, '0);
        add_row(item_of(mdc_pkg::OP_WRITE, 21'h1FFFFF, 32'h7FFFFFFF, 1'b0), 1'b1, 1'b1,
                resp_of(mdc_pkg::KIND_REQ, 1'b0, 21'h1FFFFF, '0, mdc_pkg::BUS_RDX,
                        mdc_pkg::SNOOP_NONE, 1'b1));
        add_row(item_of(mdc_pkg::OP_READ, 21'h000000, 32'h0, 1'b0), 1'b1, 1'b1,
                resp_of(mdc_pkg::KIND_WAIT, 1'b0, 21'h000000, '0, mdc_pkg::BUS_RD,
                        mdc_pkg::SNOOP_NONE, 1'b1));
        for (int i = 0; i < 8; i++)
            add_row(item_of(mdc_pkg::OP_FILL, {18'h3FFFF, 3'(i)}, pat[i], 1'(i)),
                    1'b1, 1'b0, '0);
        add_row(item_of(mdc_pkg::OP_FILL, 21'h1FFFFF, 32'h0, 1'b1), 1'b1, 1'b0, '0);
        add_row(item_of(mdc_pkg::OP_WRITE, 21'h1FFFFF, 32'h80000000, 1'b0), 1'b1, 1'b1,
                resp_of(mdc_pkg::KIND_DONE, 1'b0, 21'h1FFFFF, '0, mdc_pkg::BUS_RD,
                        mdc_pkg::SNOOP_NONE, 1'b1));
        add_row(item_of(mdc_pkg::OP_READ, 21'h1FFFF8, 32'h0, 1'b0), 1'b0, 1'b0, '0);
        add_row(item_of(mdc_pkg::OP_READ, 21'h0001F8, 32'h0, 1'b0), 1'b0, 1'b0, '0);
        add_row(item_of(mdc_pkg::OP_WRITE, 21'h0001F9, 32'hCAFEF00D, 1'b1), 1'b0, 1'b0, '0);
        add_row(item_of(mdc_pkg::OP_SNOOP_RDX, 21'h1FFFFF, 32'h0, 1'b0), 1'b0, 1'b0, '0);
    endfunction

    task automatic offer(input t_cache_item it);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, it.shared, it.data, it.addr};
        i_s_tuser  <= it.op;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
    endtask

    initial begin
        t_cache_item it;
        bit          eff;
        int          rand_done;
        bit          phase_b;
        bit          phase_c;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= '0;
        i_m_tready  <= 1'b0;
        tx_idle_pct = 9;
        rx_idle_pct = 76;
        hold_ask    = 1'b0;
        hold_left   = 0;
        rand_done   = 0;
        phase_b     = 1'b0;
        phase_c     = 1'b0;
        reset_cache_state();
        build_directed();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            offer(directed[i].item);
            predict_mesi_step(directed[i].item, !directed[i].typed, eff);
            if (directed[i].typed && directed[i].has_resp)
                responses_due.push_back(directed[i].resp);
            items_sent++;
        end

        while (rand_done < RANDOM_ITEMS) begin
            if (rand_done == RANDOM_ITEMS / 3 && !phase_b) begin
                tx_idle_pct = 76;
                rx_idle_pct = 9;
                phase_b = 1'b1;
            end
            if (rand_done == 2 * RANDOM_ITEMS / 3 && !phase_c) begin
                // drain everything, then stall the receiver while words keep coming
                if (responses_due.size() != 0) begin
                    i_s_tvalid <= 1'b0;
                    while (responses_due.size() != 0)
                        @(posedge i_clk);
                end
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                hold_ask = 1'b1;
                phase_c = 1'b1;
            end
            do
                it = next_item();
            while (touches_unwritten(it));
            offer(it);
            predict_mesi_step(it, 1'b1, eff);
            items_sent++;
            if (eff)
                rand_done++;
        end

        i_s_tvalid <= 1'b0;
        while (responses_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d items (%0d directed) and checked %0d result words",
                 items_sent, directed.size(), words_checked);
        $display("saw %0d writeback words and %0d snoop flushes, %0d mismatches",
                 wb_words, flushes, mismatches);
        if (mismatches == 0)
            $display("tb_mesi_direct_mapped_cache passed");
        else
            $display("tb_mesi_direct_mapped_cache failed");
        $finish;
    end

endmodule
